@@ rtl/core/grid_layer_merge_macros.svh @@
// ----------------------------------------------------------------------------
// Grid layer merge assertion macros
// Shared property wrappers for the port checker.
// ----------------------------------------------------------------------------
`ifndef GRID_LAYER_MERGE_MACROS_SVH
`define GRID_LAYER_MERGE_MACROS_SVH

// check a property on every clock edge outside reset
`define GLM_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// check a property on every clock edge, reset included
`define GLM_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ rtl/core/glm_pkg.sv @@
// ----------------------------------------------------------------------------
// Grid layer merge package
// Sizes, request and mode codes, and controller/datapath link types.
// ----------------------------------------------------------------------------
package glm_pkg;

   // grid geometry
   localparam int MAX_WIDTH   = 256;
   localparam int MAX_HEIGHT  = 256;
   localparam int STORE_CELLS = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W      = $clog2(STORE_CELLS);
   localparam int DIM_W       = 9;
   localparam int COORD_W     = 8;
   localparam int CELL_W      = 8;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 9;

   // request codes
   localparam logic [2:0] REQ_WR_LAYER = 3'd0;
   localparam logic [2:0] REQ_RD_LAYER = 3'd1;
   localparam logic [2:0] REQ_WR_MAIN  = 3'd2;
   localparam logic [2:0] REQ_RD_MAIN  = 3'd3;
   localparam logic [2:0] REQ_MERGE    = 3'd4;

   // merge modes
   localparam logic [1:0] MODE_KNOWN = 2'd0;
   localparam logic [1:0] MODE_ALL   = 2'd1;
   localparam logic [1:0] MODE_MAX   = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MAP_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAP_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NO_INFO    = 2'd2;

   // result status codes
   localparam logic STATUS_DONE    = 1'b0;
   localparam logic STATUS_IGNORED = 1'b1;

   // one request word
   typedef struct packed {
      logic [2:0]         req_type;
      logic [COORD_W-1:0] cell_x;
      logic [COORD_W-1:0] cell_y;
      logic [COORD_W-1:0] end_x;
      logic [COORD_W-1:0] end_y;
      logic [CELL_W-1:0]  cell_value;
      logic [1:0]         merge_mode;
   } glm_item_type;

   // controller to datapath
   typedef struct packed {
      logic load;    // capture the request word
      logic calc;    // form the row base address
      logic access;  // single cell read or write
      logic step;    // issue one merge cell and advance
      logic emit;    // load the result register
   } glm_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic bad;       // request ignored
      logic empty;     // merge region holds no cell
      logic is_merge;  // valid merge request
      logic last;      // current cell is the last of the region
      logic out_free;  // result register can take a word
   } glm_stat_type;

endpackage

@@ rtl/core/glm_if.sv @@
// ----------------------------------------------------------------------------
// Grid layer merge channels
// Request and response valid/ready channels with their payload.
// ----------------------------------------------------------------------------
interface glm_req_if;
   logic                        valid;
   logic                        ready;
   logic [2:0]                  req_type;
   logic [glm_pkg::COORD_W-1:0] cell_x;
   logic [glm_pkg::COORD_W-1:0] cell_y;
   logic [glm_pkg::COORD_W-1:0] end_x;
   logic [glm_pkg::COORD_W-1:0] end_y;
   logic [glm_pkg::CELL_W-1:0]  cell_value;
   logic [1:0]                  merge_mode;

   modport source (output valid, req_type, cell_x, cell_y, end_x, end_y, cell_value,
                   merge_mode, input ready);
   modport sink   (input valid, req_type, cell_x, cell_y, end_x, end_y, cell_value,
                   merge_mode, output ready);
endinterface

interface glm_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [glm_pkg::CELL_W-1:0] read_value;
   logic                       status;

   modport source (output valid, read_value, status, input ready);
   modport sink   (input valid, read_value, status, output ready);
endinterface

@@ rtl/core/grid_layer_merge.sv @@
// ----------------------------------------------------------------------------
// Grid layer merge
// Layer and main occupancy grids with single cell access and region merge.
// ----------------------------------------------------------------------------
// A single cell read or write passes through capture, row-base multiply,
// memory access and result load before the next acceptance; a request
// rejected for range, an unknown code or an empty region skips the access.
// A region merge reads one cell of each grid per cycle and writes the main
// cell in the cycle after its read, then drains and loads the result. Each
// grid memory has a single read and a single write port. Results wait in an
// output register, and the next word is taken while one waits.
// The grids have no reset: a cell reads back only after it has been written.
// ----------------------------------------------------------------------------
module grid_layer_merge (
   input  logic                           clock,
   input  logic                           reset,
   glm_req_if.sink                        req_chan,
   glm_rsp_if.source                      rsp_chan,
   input  logic                           csr_we,
   input  logic [glm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [glm_pkg::CSR_DATA_W-1:0] csr_wdata
);

   glm_pkg::glm_item_type item;
   glm_pkg::glm_cmd_type  cmd;
   glm_pkg::glm_stat_type stat;
   logic                  req_ready;

   // pack the request word
   always_comb begin
      item.req_type   = req_chan.req_type;
      item.cell_x     = req_chan.cell_x;
      item.cell_y     = req_chan.cell_y;
      item.end_x      = req_chan.end_x;
      item.end_y      = req_chan.end_y;
      item.cell_value = req_chan.cell_value;
      item.merge_mode = req_chan.merge_mode;
   end

   assign req_chan.ready = req_ready;

   glm_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   glm_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .item       (item),
      .cmd        (cmd),
      .stat       (stat),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_valid  (rsp_chan.valid),
      .rsp_ready  (rsp_chan.ready),
      .read_value (rsp_chan.read_value),
      .status     (rsp_chan.status)
   );

endmodule

@@ rtl/core/glm_datapath.sv @@
// ----------------------------------------------------------------------------
// Grid layer merge datapath
// Config registers, both grid memories, region walk counters and result word.
// ----------------------------------------------------------------------------
module glm_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  glm_pkg::glm_item_type             item,
   input  glm_pkg::glm_cmd_type              cmd,
   output glm_pkg::glm_stat_type             stat,
   input  logic                              csr_we,
   input  logic [glm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [glm_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [glm_pkg::CELL_W-1:0]        read_value,
   output logic                              status
);

   localparam int AW = glm_pkg::ADDR_W;
   localparam int CW = glm_pkg::COORD_W;
   localparam int DW = glm_pkg::DIM_W;
   localparam int VW = glm_pkg::CELL_W;

   // configuration
   logic [DW-1:0] map_width_ff, map_height_ff;
   logic [VW-1:0] no_info_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         map_width_ff  <= DW'(glm_pkg::MAX_WIDTH);
         map_height_ff <= DW'(glm_pkg::MAX_HEIGHT);
         no_info_ff    <= '1;
      end else if (csr_we) begin
         unique case (csr_index)
            glm_pkg::CSR_MAP_WIDTH:  map_width_ff  <= csr_wdata;
            glm_pkg::CSR_MAP_HEIGHT: map_height_ff <= csr_wdata;
            glm_pkg::CSR_NO_INFO:    no_info_ff    <= csr_wdata[VW-1:0];
            default: ;
         endcase
      end
   end

   // clamp the grid size to between one and the store limits
   logic [DW-1:0] w_eff, h_eff;

   always_comb begin
      priority if (map_width_ff == '0) w_eff = DW'(1);
      else if (map_width_ff > DW'(glm_pkg::MAX_WIDTH)) w_eff = DW'(glm_pkg::MAX_WIDTH);
      else w_eff = map_width_ff;
      priority if (map_height_ff == '0) h_eff = DW'(1);
      else if (map_height_ff > DW'(glm_pkg::MAX_HEIGHT)) h_eff = DW'(glm_pkg::MAX_HEIGHT);
      else h_eff = map_height_ff;
   end

   // captured request word
   glm_pkg::glm_item_type item_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) item_ff <= item;
   end

   // range and emptiness checks
   logic [DW-1:0] x0_w, y0_w, x1_w, y1_w;
   logic          single, mode_all, mode_incl, bad, empty;
   logic [CW-1:0] x_last, y_last;

   always_comb begin
      x0_w      = {1'b0, item_ff.cell_x};
      y0_w      = {1'b0, item_ff.cell_y};
      x1_w      = {1'b0, item_ff.end_x};
      y1_w      = {1'b0, item_ff.end_y};
      single    = item_ff.req_type < glm_pkg::REQ_MERGE;
      mode_all  = item_ff.merge_mode == glm_pkg::MODE_ALL;
      mode_incl = (item_ff.merge_mode == glm_pkg::MODE_KNOWN) ||
                  (item_ff.merge_mode == glm_pkg::MODE_MAX);
      priority if (single)
         bad = (x0_w >= w_eff) || (y0_w >= h_eff);
      else if (item_ff.req_type == glm_pkg::REQ_MERGE && mode_all)
         bad = (x0_w >= w_eff) || (y0_w >= h_eff) || (x1_w > w_eff) || (y1_w > h_eff);
      else if (item_ff.req_type == glm_pkg::REQ_MERGE && mode_incl)
         bad = (x0_w >= w_eff) || (y0_w >= h_eff) || (x1_w >= w_eff) || (y1_w >= h_eff);
      else
         bad = 1'b1;
      if (mode_all) begin
         empty  = (item_ff.cell_x >= item_ff.end_x) || (item_ff.cell_y >= item_ff.end_y);
         x_last = item_ff.end_x - CW'(1);
         y_last = item_ff.end_y - CW'(1);
      end else begin
         empty  = (item_ff.cell_x > item_ff.end_x) || (item_ff.cell_y > item_ff.end_y);
         x_last = item_ff.end_x;
         y_last = item_ff.end_y;
      end
   end

   // region walk: row base plus column
   logic [AW-1:0] row_base_ff, row_base_in;
   logic [CW-1:0] xc_ff, yc_ff;
   logic [AW-1:0] addr;
   logic [DW+CW-1:0] row_mul;
   logic          at_row_end;

   always_comb begin
      row_mul    = (DW+CW)'(item_ff.cell_y) * (DW+CW)'(w_eff);
      at_row_end = xc_ff == x_last;
      addr       = row_base_ff + AW'(xc_ff);
      row_base_in = row_base_ff;
      if (cmd.calc) row_base_in = AW'(row_mul);
      else if (cmd.step && at_row_end) row_base_in = row_base_ff + AW'(w_eff);
   end

   always_ff @(posedge clock) begin
      row_base_ff <= row_base_in;
      if (cmd.load) begin
         xc_ff <= item.cell_x;
         yc_ff <= item.cell_y;
      end else if (cmd.step) begin
         if (at_row_end) begin
            xc_ff <= item_ff.cell_x;
            yc_ff <= yc_ff + CW'(1);
         end else begin
            xc_ff <= xc_ff + CW'(1);
         end
      end
   end

   // merge write-back in the cycle after the reads
   logic          issue_d_ff;
   logic [AW-1:0] addr_d_ff;

   always_ff @(posedge clock) begin
      if (reset) issue_d_ff <= 1'b0;
      else       issue_d_ff <= cmd.step;
   end

   always_ff @(posedge clock) begin
      addr_d_ff <= addr;
   end

   // grid memories
   logic [VW-1:0] layer_mem [glm_pkg::STORE_CELLS];
   logic [VW-1:0] main_mem  [glm_pkg::STORE_CELLS];
   logic [VW-1:0] rd_layer_ff, rd_main_ff;
   logic          rd_en, we_layer, we_main, merge_wr;
   logic [AW-1:0] main_waddr;
   logic [VW-1:0] main_wdata;

   always_comb begin
      rd_en    = cmd.access || cmd.step;
      we_layer = cmd.access && (item_ff.req_type == glm_pkg::REQ_WR_LAYER);
      unique case (item_ff.merge_mode)
         glm_pkg::MODE_ALL:   merge_wr = 1'b1;
         glm_pkg::MODE_KNOWN: merge_wr = rd_layer_ff != no_info_ff;
         default:             merge_wr = (rd_layer_ff != no_info_ff) &&
                                         ((rd_main_ff == no_info_ff) ||
                                          (rd_main_ff < rd_layer_ff));
      endcase
      we_main    = (cmd.access && (item_ff.req_type == glm_pkg::REQ_WR_MAIN)) ||
                   (issue_d_ff && merge_wr);
      main_waddr = issue_d_ff ? addr_d_ff : addr;
      main_wdata = issue_d_ff ? rd_layer_ff : item_ff.cell_value;
   end

   always_ff @(posedge clock) begin
      if (we_layer) layer_mem[addr] <= item_ff.cell_value;
      if (rd_en)    rd_layer_ff     <= layer_mem[addr];
   end

   always_ff @(posedge clock) begin
      if (we_main) main_mem[main_waddr] <= main_wdata;
      if (rd_en)   rd_main_ff           <= main_mem[addr];
   end

   // result register
   logic          rsp_valid_ff;
   logic [VW-1:0] read_value_ff, read_value_in;
   logic          status_ff;

   always_comb begin
      read_value_in = '0;
      if (!bad && item_ff.req_type == glm_pkg::REQ_RD_LAYER) read_value_in = rd_layer_ff;
      if (!bad && item_ff.req_type == glm_pkg::REQ_RD_MAIN)  read_value_in = rd_main_ff;
   end

   always_ff @(posedge clock) begin
      if (reset)          rsp_valid_ff <= 1'b0;
      else if (cmd.emit)  rsp_valid_ff <= 1'b1;
      else if (rsp_ready) rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         read_value_ff <= read_value_in;
         status_ff     <= bad ? glm_pkg::STATUS_IGNORED : glm_pkg::STATUS_DONE;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign read_value = read_value_ff;
   assign status     = status_ff;

   // status to the controller
   always_comb begin
      stat.bad      = bad;
      stat.empty    = empty;
      stat.is_merge = !single;
      stat.last     = at_row_end && (yc_ff == y_last);
      stat.out_free = !rsp_valid_ff || rsp_ready;
   end

endmodule

@@ rtl/core/glm_control.sv @@
// ----------------------------------------------------------------------------
// Grid layer merge controller
// Sequences decode, single cell access, region walk and result hand-off.
// ----------------------------------------------------------------------------
module glm_control (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  glm_pkg::glm_stat_type stat,
   output glm_pkg::glm_cmd_type  cmd
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_DECODE = 3'd1;
   localparam logic [2:0] ST_ACCESS = 3'd2;
   localparam logic [2:0] ST_MERGE  = 3'd3;
   localparam logic [2:0] ST_DRAIN  = 3'd4;
   localparam logic [2:0] ST_RESP   = 3'd5;

   logic [2:0] state_ff, state_in;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.load = req_valid;
            if (req_valid) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            cmd.calc = 1'b1;
            priority if (stat.bad) state_in = ST_RESP;
            else if (stat.is_merge && stat.empty) state_in = ST_RESP;
            else if (stat.is_merge) state_in = ST_MERGE;
            else state_in = ST_ACCESS;
         end
         ST_ACCESS: begin
            cmd.access = 1'b1;
            state_in   = ST_RESP;
         end
         ST_MERGE: begin
            cmd.step = 1'b1;
            if (stat.last) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            cmd.emit = stat.out_free;
            if (stat.out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   assign req_ready = state_ff == ST_IDLE;

endmodule

@@ rtl/core/glm_checker.sv @@
// ----------------------------------------------------------------------------
// Grid layer merge port checker
// Watches the top level ports for handshake and result consistency.
// ----------------------------------------------------------------------------
`include "grid_layer_merge_macros.svh"

module glm_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [glm_pkg::CELL_W-1:0] read_value,
   input logic                       status
);

   // hold a stalled result word
   `GLM_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(read_value) && $stable(status), "stalled result word changed")

   // no result word straight out of reset
   `GLM_ASSERT_ALWAYS(a_reset_clear, reset |=> !rsp_valid, "result valid after reset")

   // drop ready once a word is taken, and raise no result valid straight away
   `GLM_ASSERT(a_one_at_a_time, req_valid && req_ready |=> !req_ready && !$rose(rsp_valid), "request taken while busy or result too early")

   // ignored requests return zero
   `GLM_ASSERT(a_ignored_zero, rsp_valid && status |-> read_value == '0, "ignored request returned data")

endmodule

bind grid_layer_merge glm_checker u_glm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_chan.valid),
   .req_ready  (req_chan.ready),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .read_value (rsp_chan.read_value),
   .status     (rsp_chan.status)
);
